// ===== rtl/core/csb_pkg.sv =====
// Shared types and constants for the clipped sprite blitter.
// Used by csb_ctrl, csb_dp and clipped_sprite_blit; depends on nothing else.
package csb_pkg;

   // largest sprite edge the pixel walk handles
   localparam int MAX_DIM = 1024;
   localparam int COL_W   = $clog2(MAX_DIM);
   localparam int ROW_W   = $clog2(2 * MAX_DIM);
   localparam int ROW_MAX = 2 * MAX_DIM - 1;

   localparam int POS_W   = 12;
   localparam int DIM_W   = 11;
   localparam int IDX_W   = 8;
   localparam int BYTE_W  = 8;
   localparam int ADDR_W  = 30;
   localparam int PROD_W  = 2 * DIM_W;
   // signed span for row/column plus origin
   localparam int SUM_W   = ((ROW_W > POS_W) ? ROW_W : POS_W) + 2;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIM_W-1:0] SCREEN_WIDTH_RESET  = DIM_W'(64);
   localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RESET = DIM_W'(64);

   // register index, taken from paddr bit 2
   localparam logic REG_SCREEN_WIDTH  = 1'b0;
   localparam logic REG_SCREEN_HEIGHT = 1'b1;

   // request kind (req_tuser)
   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_PIXEL  = 1'b1;

   // response kind (rsp_tuser)
   localparam logic KIND_FRAME_OFFSET = 1'b0;
   localparam logic KIND_SCREEN_WRITE = 1'b1;

   typedef struct packed {
      logic load;      // capture an accepted request
      logic mul;       // run the shared multiplier
      logic out_load;  // fill the response register
   } ctl_cmd_type;

   typedef struct packed {
      logic emit;      // the item in flight produces a response
   } dp_status_type;

endpackage

// ===== rtl/core/csb_ctrl.sv =====
// Sequencer of the clipped sprite blitter: request intake, multiply and
// finish steps, response valid. Depends on csb_pkg.
module csb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  csb_pkg::dp_status_type status,
   output csb_pkg::ctl_cmd_type   cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.mul      = 1'b0;
      cmd.out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold until the response register frees up; drop silently otherwise
            if (!status.emit) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== rtl/core/csb_dp.sv =====
// Datapath of the clipped sprite blitter: sprite state, pixel walk, clip test,
// shared multiplier and response payload register. Depends on csb_pkg.
module csb_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  csb_pkg::ctl_cmd_type               cmd,
   output csb_pkg::dp_status_type             status,
   input  logic [csb_pkg::DIM_W-1:0]          screen_width,
   input  logic [csb_pkg::DIM_W-1:0]          screen_height,
   input  logic                               in_cmd,
   input  logic signed [csb_pkg::POS_W-1:0]   in_pos_x,
   input  logic signed [csb_pkg::POS_W-1:0]   in_pos_y,
   input  logic [csb_pkg::DIM_W-1:0]          in_sprite_width,
   input  logic [csb_pkg::DIM_W-1:0]          in_sprite_height,
   input  logic [csb_pkg::IDX_W-1:0]          in_frame_index,
   input  logic [csb_pkg::BYTE_W-1:0]         in_red,
   input  logic [csb_pkg::BYTE_W-1:0]         in_green,
   input  logic [csb_pkg::BYTE_W-1:0]         in_blue,
   input  logic [csb_pkg::BYTE_W-1:0]         in_alpha,
   output logic                               out_kind,
   output logic [csb_pkg::ADDR_W-1:0]         out_address,
   output logic [csb_pkg::BYTE_W-1:0]         out_red,
   output logic [csb_pkg::BYTE_W-1:0]         out_green,
   output logic [csb_pkg::BYTE_W-1:0]         out_blue,
   output logic                               out_mark
);

   localparam int SW = csb_pkg::SUM_W;

   // sprite state
   logic signed [csb_pkg::POS_W-1:0] origin_x_ff, origin_y_ff;
   logic [csb_pkg::DIM_W-1:0]        width_ff, height_ff;
   logic [csb_pkg::COL_W-1:0]        col_ff;
   logic [csb_pkg::ROW_W-1:0]        row_ff;
   logic                             offscreen_ff;

   // item in flight
   logic                             kind_ff;
   logic                             draw_ff, draw_in;
   logic [csb_pkg::DIM_W-1:0]        sy_ff, sx_ff;
   logic [csb_pkg::IDX_W-1:0]        idx_ff;
   logic [csb_pkg::BYTE_W-1:0]       red_ff, green_ff, blue_ff;
   logic [csb_pkg::PROD_W-1:0]       prod_ff, prod_in;

   // response payload
   logic                             okind_ff;
   logic [csb_pkg::ADDR_W-1:0]       oaddr_ff, oaddr_in;
   logic [csb_pkg::BYTE_W-1:0]       ored_ff, ogreen_ff, oblue_ff;
   logic                             omark_ff;

   logic signed [SW-1:0]             sy, sx, next_col, width_s, height_s;
   logic signed [SW-1:0]             hdr_x, hdr_y, hdr_w, hdr_h, scr_w, scr_h;
   logic                             hdr_off, wrap;
   logic [csb_pkg::DIM_W-1:0]        mul_a, mul_b;
   logic [csb_pkg::PROD_W+csb_pkg::IDX_W-1:0] frame_prod;
   logic [csb_pkg::PROD_W:0]         pix_sum;

   assign scr_w    = SW'($signed({1'b0, screen_width}));
   assign scr_h    = SW'($signed({1'b0, screen_height}));
   assign width_s  = SW'($signed({1'b0, width_ff}));
   assign height_s = SW'($signed({1'b0, height_ff}));

   // header: whole-sprite reject
   assign hdr_x   = SW'(in_pos_x);
   assign hdr_y   = SW'(in_pos_y);
   assign hdr_w   = SW'($signed({1'b0, in_sprite_width}));
   assign hdr_h   = SW'($signed({1'b0, in_sprite_height}));
   assign hdr_off = (hdr_y < -hdr_h) || (hdr_y > scr_h) ||
                    (hdr_x > scr_w) || (hdr_x < -hdr_w);

   // pixel: screen position and walk advance
   assign sy       = SW'($signed({1'b0, row_ff})) + SW'(origin_y_ff);
   assign sx       = SW'($signed({1'b0, col_ff})) + SW'(origin_x_ff);
   assign next_col = SW'($signed({1'b0, col_ff})) + SW'(1);
   assign wrap     = (next_col >= width_s) || (next_col >= SW'(csb_pkg::MAX_DIM));

   assign draw_in = !offscreen_ff &&
                    (SW'($signed({1'b0, row_ff})) < height_s) &&
                    (SW'($signed({1'b0, col_ff})) < width_s) &&
                    (sy >= SW'(0)) && (sy < scr_h) &&
                    (sx >= SW'(0)) && (sx < scr_w) &&
                    (in_alpha != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         width_ff     <= '0;
         height_ff    <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         offscreen_ff <= 1'b1;
      end else if (cmd.load) begin
         if (in_cmd == csb_pkg::CMD_HEADER) begin
            origin_x_ff  <= in_pos_x;
            origin_y_ff  <= in_pos_y;
            width_ff     <= in_sprite_width;
            height_ff    <= in_sprite_height;
            col_ff       <= '0;
            row_ff       <= '0;
            offscreen_ff <= hdr_off;
         end else if (wrap) begin
            col_ff <= '0;
            // saturate past the last row
            if (row_ff < csb_pkg::ROW_W'(csb_pkg::ROW_MAX)) begin
               row_ff <= row_ff + csb_pkg::ROW_W'(1);
            end
         end else begin
            col_ff <= csb_pkg::COL_W'(next_col);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= in_cmd;
         draw_ff  <= (in_cmd == csb_pkg::CMD_PIXEL) && draw_in;
         sy_ff    <= csb_pkg::DIM_W'(sy);
         sx_ff    <= csb_pkg::DIM_W'(sx);
         idx_ff   <= in_frame_index;
         red_ff   <= in_red;
         green_ff <= in_green;
         blue_ff  <= in_blue;
      end
   end

   assign status.emit = (kind_ff == csb_pkg::CMD_HEADER) || draw_ff;

   // shared multiplier: sprite area for a header, row stride for a pixel
   always_comb begin
      if (kind_ff == csb_pkg::CMD_HEADER) begin
         mul_a = width_ff;
         mul_b = height_ff;
      end else begin
         mul_a = sy_ff;
         mul_b = screen_width;
      end
      prod_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
   end

   assign frame_prod = prod_ff * idx_ff;
   assign pix_sum    = {1'b0, prod_ff} + (csb_pkg::PROD_W+1)'(sx_ff);

   always_comb begin
      if (kind_ff == csb_pkg::CMD_HEADER) begin
         oaddr_in = {frame_prod[csb_pkg::ADDR_W-3:0], 2'b00};
      end else begin
         oaddr_in = csb_pkg::ADDR_W'({pix_sum, 2'b00});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         okind_ff <= (kind_ff == csb_pkg::CMD_HEADER) ? csb_pkg::KIND_FRAME_OFFSET
                                                      : csb_pkg::KIND_SCREEN_WRITE;
         oaddr_ff <= oaddr_in;
         if (kind_ff == csb_pkg::CMD_HEADER) begin
            ored_ff   <= '0;
            ogreen_ff <= '0;
            oblue_ff  <= '0;
            omark_ff  <= 1'b0;
         end else begin
            ored_ff   <= red_ff;
            ogreen_ff <= green_ff;
            oblue_ff  <= blue_ff;
            omark_ff  <= 1'b1;
         end
      end
   end

   assign out_kind    = okind_ff;
   assign out_address = oaddr_ff;
   assign out_red     = ored_ff;
   assign out_green   = ogreen_ff;
   assign out_blue    = oblue_ff;
   assign out_mark    = omark_ff;

endmodule

// ===== rtl/core/clipped_sprite_blit.sv =====
// Top level of the clipped sprite blitter: stream ports, screen size registers,
// sequencer and datapath. Depends on csb_pkg, csb_ctrl and csb_dp.
//
//   Channel  Direction  Moves
//   req_*    in         sprite header or one sprite pixel
//   rsp_*    out        frame offset or screen write
//   csr_*    in/out     screen_width (0x0), screen_height (0x4)
//
// Each request goes through capture and clip test, one pass through the
// shared multiplier, then the address add into the response register.
// A dropped pixel goes through the same steps with no response.
// A request is taken while the previous response still waits; a stalled
// response holds only the finish step. Synchronous active-high reset clears the
// sprite state to "nothing drawn" and sets both screen sizes to 64.
module clipped_sprite_blit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pos_x[11:0], pos_y[23:12], sprite_width[34:24], sprite_height[45:35],
   // frame_index[53:46], pixel_red[61:54], pixel_green[69:62],
   // pixel_blue[77:70], pixel_alpha[85:78], zero[87:86]
   input  logic [csb_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // byte_address[29:0], out_red[37:30], out_green[45:38], out_blue[53:46],
   // drawn_mark[54], zero[55]
   output logic [csb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // result_kind[0]
   output logic                               rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [csb_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [csb_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [csb_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic [csb_pkg::DIM_W-1:0]  screen_width_ff, screen_height_ff;
   logic                       csr_write;
   csb_pkg::ctl_cmd_type       cmd;
   csb_pkg::dp_status_type     status;
   logic                       out_kind, out_mark;
   logic [csb_pkg::ADDR_W-1:0] out_address;
   logic [csb_pkg::BYTE_W-1:0] out_red, out_green, out_blue;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= csb_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= csb_pkg::SCREEN_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            csb_pkg::REG_SCREEN_WIDTH: begin
               screen_width_ff <= csr_pwdata[csb_pkg::DIM_W-1:0];
            end
            csb_pkg::REG_SCREEN_HEIGHT: begin
               screen_height_ff <= csr_pwdata[csb_pkg::DIM_W-1:0];
            end
            default: begin
               screen_width_ff <= screen_width_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         csb_pkg::REG_SCREEN_WIDTH: begin
            csr_prdata = csb_pkg::CSR_DATA_W'(screen_width_ff);
         end
         csb_pkg::REG_SCREEN_HEIGHT: begin
            csr_prdata = csb_pkg::CSR_DATA_W'(screen_height_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   csb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   csb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .screen_width     (screen_width_ff),
      .screen_height    (screen_height_ff),
      .in_cmd           (req_tuser),
      .in_pos_x         ($signed(req_tdata[11:0])),
      .in_pos_y         ($signed(req_tdata[23:12])),
      .in_sprite_width  (req_tdata[34:24]),
      .in_sprite_height (req_tdata[45:35]),
      .in_frame_index   (req_tdata[53:46]),
      .in_red           (req_tdata[61:54]),
      .in_green         (req_tdata[69:62]),
      .in_blue          (req_tdata[77:70]),
      .in_alpha         (req_tdata[85:78]),
      .out_kind         (out_kind),
      .out_address      (out_address),
      .out_red          (out_red),
      .out_green        (out_green),
      .out_blue         (out_blue),
      .out_mark         (out_mark)
   );

   assign rsp_tuser = out_kind;
   assign rsp_tdata = {1'b0, out_mark, out_blue, out_green, out_red, out_address};

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in flight");

   // frame offsets carry no color and no drawn mark
   a_offset_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == csb_pkg::KIND_FRAME_OFFSET) |-> (rsp_tdata[54:30] == '0))
      else $error("frame offset response carries pixel bytes");

   // screen writes are marked drawn
   a_write_marked: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == csb_pkg::KIND_SCREEN_WRITE) |-> rsp_tdata[54])
      else $error("screen write without drawn mark");

   // every byte address is word aligned
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == 2'b00))
      else $error("unaligned byte address");

endmodule
